// ----- hw/rtl/linear_least_squares_fit_unit_assert.svh -----
// Assertion macros for the least-squares fit unit.
// Included by the top level; depends on nothing else.
`ifndef LINEAR_LEAST_SQUARES_FIT_UNIT_ASSERT_SVH
`define LINEAR_LEAST_SQUARES_FIT_UNIT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define LLSF_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define LLSF_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/llsf_pkg.sv -----
// Shared types, widths and codes of the least-squares fit unit.
// Used by the controller, the datapath and the top level; no dependencies.
package llsf_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;

  localparam int SX_W   = 29;   // sum of x and sum of y
  localparam int SXX_W  = 44;   // sum of x squared
  localparam int SXY_W  = 45;   // sum of x times y
  localparam int OP_W   = 45;   // signed multiplier operand
  localparam int MAG_W  = 44;   // operand magnitude
  localparam int PROD_W = 2 * MAG_W;
  localparam int NUM_W  = 72;   // denominator and numerators
  localparam int DVD_W  = 80;   // dividend magnitude
  localparam int DVS_W  = 56;   // divisor
  localparam int LINE_W = 42;   // unsaturated line value
  localparam int RES_W  = 43;   // residual
  localparam int LOSS_W = 64;
  localparam int MEAN_W = 48;
  localparam int COEF_W = 32;
  localparam int SLOPE_SH = 16;
  localparam int INTC_SH  = 8;
  localparam int MUL_CNT_W = $clog2(MAG_W + 1);
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_FIT  = 2'd0,
    MODE_EVAL = 2'd1,
    MODE_LOSS = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_COEF = 2'd0,
    KIND_LINE = 2'd1,
    KIND_LOSS = 2'd2
  } kind_t;

  // Operand pairs of the shared multiplier, fit-close order first, then the loss square.
  typedef enum logic [2:0] {
    MUL_N_SXX  = 3'd0,
    MUL_SX_SX  = 3'd1,
    MUL_N_SXY  = 3'd2,
    MUL_SX_SY  = 3'd3,
    MUL_SXX_SY = 3'd4,
    MUL_SX_SXY = 3'd5,
    MUL_SQUARE = 3'd6
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_SLOPE = 2'd0,
    DIV_INTC  = 2'd1,
    DIV_MEAN  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     fit_acc;
    logic     fit_clr;
    logic     mul_start;
    logic     mul_store;
    mul_sel_t mul_sel;
    logic     coef_zero;
    logic     div_start;
    logic     div_store;
    div_sel_t div_sel;
    logic     line_mul;
    logic     line_add;
    logic     mean_empty;
    logic     out_load;
    kind_t    out_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       last;
    logic       mul_busy;
    logic       div_busy;
    logic       den_pos;
    logic       loss_full;
    logic       loss_empty;
  } stat_t;

endpackage

// ----- hw/rtl/linear_least_squares_fit_unit.sv -----
// A fit sample that does not close its run is added to the sums; a loss sample that
// does not close its run takes one 44-bit multiply unless the loss count is full; an
// evaluate result passes the line multiply, line add and emit states; closing a fit takes
// six multiplies and, with a positive denominator, two divisions, and closing a loss run
// one multiply and one division. Throughput is one item at a time, taken only while idle.
// Reset (synchronous, active high) clears all sums, counts and coefficients.
module linear_least_squares_fit_unit import llsf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic signed [15:0]       sample_x,
  input  logic signed [15:0]       sample_y,
  input  logic                     last_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               result_kind,
  output logic signed [COEF_W-1:0] slope_out,
  output logic signed [COEF_W-1:0] intercept_out,
  output logic signed [COEF_W-1:0] line_value,
  output logic [MEAN_W-1:0]        mean_loss,
  output logic                     error_flag
);

`include "linear_least_squares_fit_unit_assert.svh"

  // The controller walks each item through its steps; the datapath holds the
  // running sums, the coefficients of the latest closed fit and the result
  // register, which lets a finished result wait while new samples come in.
  cmd_t  cmd;
  stat_t stat;

  llsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  llsf_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode_in       (mode),
    .x_in          (sample_x),
    .y_in          (sample_y),
    .last_in       (last_sample),
    .result_kind   (result_kind),
    .slope_out     (slope_out),
    .intercept_out (intercept_out),
    .line_value    (line_value),
    .mean_loss     (mean_loss),
    .error_flag    (error_flag)
  );

  // The arithmetic units are quiet whenever the block can take a transfer.
  `LLSF_ASSERT_SAME(a_idle_quiet, clk, rst, in_ready, !stat.mul_busy && !stat.div_busy, "unit busy while idle")
  // Each accepted item with a real operation takes the block out of its idle state;
  // an item with the unused mode code is dropped on the spot.
  `LLSF_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready && !(&mode), !in_ready, "second item taken too early")
  // A taken result with no new load leaves the output empty.
  `LLSF_ASSERT_NEXT(a_out_drain, clk, rst, out_valid && out_ready && !cmd.out_load, !out_valid, "result repeated")

endmodule

// ----- hw/rtl/llsf_ctrl.sv -----
// Sequencing state machine of the least-squares fit unit.
// Depends on llsf_pkg; drives the datapath through cmd_t and reads stat_t.
module llsf_ctrl import llsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] mode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIT_ACC, S_PROD_START, S_PROD_WAIT, S_CHECK, S_DIV_START,
    S_DIV_WAIT, S_LINE_MUL, S_LINE_ADD, S_LOSS_SQ, S_LOSS_WAIT, S_LOSS_END, S_EMIT
  } state_t;

  state_t     state;
  logic [2:0] prod_idx;
  div_sel_t   div_sel_r;
  kind_t      kind_r;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.div_sel  = div_sel_r;
    cmd.out_kind = kind_r;
    cmd.mul_sel  = (state == S_LOSS_SQ || state == S_LOSS_WAIT) ? MUL_SQUARE
                                                                : mul_sel_t'(prod_idx);
    unique case (state)
      S_IDLE:       cmd.load_in = in_valid;
      S_FIT_ACC:    cmd.fit_acc = 1'b1;
      S_PROD_START: cmd.mul_start = 1'b1;
      S_PROD_WAIT:  cmd.mul_store = !stat.mul_busy;
      S_CHECK: begin
        cmd.fit_clr   = 1'b1;
        cmd.coef_zero = !stat.den_pos;
      end
      S_DIV_START:  cmd.div_start = 1'b1;
      S_DIV_WAIT:   cmd.div_store = !stat.div_busy;
      S_LINE_MUL:   cmd.line_mul = 1'b1;
      S_LINE_ADD:   cmd.line_add = 1'b1;
      S_LOSS_SQ:    cmd.mul_start = !stat.loss_full;
      S_LOSS_WAIT:  cmd.mul_store = !stat.mul_busy;
      S_LOSS_END:   cmd.mean_empty = stat.last && stat.loss_empty;
      S_EMIT:       cmd.out_load = !out_valid || out_ready;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prod_idx  <= '0;
      div_sel_r <= DIV_SLOPE;
      kind_r    <= KIND_COEF;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            priority case (mode)
              MODE_FIT:  state <= S_FIT_ACC;
              MODE_EVAL: state <= S_LINE_MUL;
              MODE_LOSS: state <= S_LINE_MUL;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_FIT_ACC: begin
          prod_idx <= '0;
          state    <= stat.last ? S_PROD_START : S_IDLE;
        end
        S_PROD_START: state <= S_PROD_WAIT;
        S_PROD_WAIT: begin
          if (!stat.mul_busy) begin
            if (prod_idx == 3'(MUL_SX_SXY)) begin
              state <= S_CHECK;
            end else begin
              prod_idx <= prod_idx + 3'd1;
              state    <= S_PROD_START;
            end
          end
        end
        S_CHECK: begin
          if (stat.den_pos) begin
            div_sel_r <= DIV_SLOPE;
            state     <= S_DIV_START;
          end else begin
            kind_r <= KIND_COEF;
            state  <= S_EMIT;
          end
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!stat.div_busy) begin
            unique case (div_sel_r)
              DIV_SLOPE: begin
                div_sel_r <= DIV_INTC;
                state     <= S_DIV_START;
              end
              DIV_INTC: begin
                kind_r <= KIND_COEF;
                state  <= S_EMIT;
              end
              default: begin
                kind_r <= KIND_LOSS;
                state  <= S_EMIT;
              end
            endcase
          end
        end
        S_LINE_MUL: state <= S_LINE_ADD;
        S_LINE_ADD: begin
          if (stat.mode == MODE_EVAL) begin
            kind_r <= KIND_LINE;
            state  <= S_EMIT;
          end else begin
            state <= S_LOSS_SQ;
          end
        end
        S_LOSS_SQ:   state <= stat.loss_full ? S_LOSS_END : S_LOSS_WAIT;
        S_LOSS_WAIT: if (!stat.mul_busy) state <= S_LOSS_END;
        S_LOSS_END: begin
          if (!stat.last) begin
            state <= S_IDLE;
          end else if (stat.loss_empty) begin
            kind_r <= KIND_LOSS;
            state  <= S_EMIT;
          end else begin
            div_sel_r <= DIV_MEAN;
            state     <= S_DIV_START;
          end
        end
        S_EMIT: if (cmd.out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/llsf_dp.sv -----
// Datapath of the least-squares fit unit: sums, shift-add multiplier,
// restoring divider, coefficient and loss registers, result register.
// Depends on llsf_pkg; controlled by llsf_ctrl.
module llsf_dp import llsf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [1:0]               mode_in,
  input  logic signed [15:0]       x_in,
  input  logic signed [15:0]       y_in,
  input  logic                     last_in,
  output logic [1:0]               result_kind,
  output logic signed [COEF_W-1:0] slope_out,
  output logic signed [COEF_W-1:0] intercept_out,
  output logic signed [COEF_W-1:0] line_value,
  output logic [MEAN_W-1:0]        mean_loss,
  output logic                     error_flag
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [1:0]               mode_r;
  logic                     last_r;
  logic signed [15:0]       x_r, y_r;
  logic [CNT_W-1:0]         fit_count, loss_count;
  logic signed [SX_W-1:0]   sum_x, sum_y;
  logic signed [SXX_W-1:0]  sum_xx;
  logic signed [SXY_W-1:0]  sum_xy;
  logic signed [COEF_W-1:0] slope_reg, intercept_reg;
  logic [LOSS_W-1:0]        loss_sum;
  logic [MEAN_W-1:0]        mean_r;
  logic                     err_r;
  logic signed [NUM_W-1:0]  tmp, den, num_s, num_i;
  logic signed [47:0]       prod_sx;
  logic signed [LINE_W-1:0] line_v;

  logic                     mul_busy, mul_neg;
  logic [MUL_CNT_W-1:0]     mul_cnt;
  logic [PROD_W-1:0]        mul_acc, mul_mcd;
  logic [MAG_W-1:0]         mul_mlt;
  logic                     div_busy, div_neg;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [DVS_W-1:0]         div_rem, div_dvs;
  logic [DVD_W-1:0]         div_dq;

  logic signed [31:0]       xx, xy;
  logic signed [OP_W-1:0]   op_a, op_b, n_op;
  logic [MAG_W-1:0]         a_mag, b_mag;
  logic signed [23:0]       y_shift;
  logic signed [RES_W-1:0]  res_val;
  logic signed [PROD_W:0]   prod_s;
  logic signed [NUM_W-1:0]  prod_n, fit_diff;
  logic [LOSS_W-1:0]        term;
  logic [LOSS_W:0]          loss_add;
  logic [DVS_W:0]           trial;
  logic [NUM_W-1:0]         mag_s, mag_i;
  logic [DVD_W-1:0]         dvd_sel;
  logic [DVS_W-1:0]         dvs_sel;
  logic                     neg_sel;
  logic [COEF_W:0]          coef_res;
  logic                     mean_over, sum_full;
  logic                     line_hi, line_lo;
  logic [COEF_W-1:0]        line_sat;

  // Saturates a quotient magnitude with its sign to a signed 32-bit value;
  // the top bit of the result flags saturation.
  function automatic logic [COEF_W:0] coef_sat(input logic [DVD_W-1:0] q,
                                                input logic neg);
    logic [COEF_W:0] r;
    if (neg) begin
      if ((|q[DVD_W-1:COEF_W]) || (q[COEF_W-1] && (|q[COEF_W-2:0]))) begin
        r = {1'b1, COEF_MIN};
      end else begin
        r = {1'b0, -q[COEF_W-1:0]};
      end
    end else begin
      if (|q[DVD_W-1:COEF_W-1]) begin
        r = {1'b1, COEF_MAX};
      end else begin
        r = {1'b0, q[COEF_W-1:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    xx      = x_r * x_r;
    xy      = x_r * y_r;
    n_op    = OP_W'(fit_count);
    y_shift = $signed({y_r, 8'h00});
    res_val = RES_W'(line_v) - RES_W'(y_shift);
    unique case (cmd.mul_sel)
      MUL_N_SXX: begin
        op_a = n_op;  op_b = OP_W'(sum_xx);
      end
      MUL_SX_SX: begin
        op_a = OP_W'(sum_x);  op_b = OP_W'(sum_x);
      end
      MUL_N_SXY: begin
        op_a = n_op;  op_b = OP_W'(sum_xy);
      end
      MUL_SX_SY: begin
        op_a = OP_W'(sum_x);  op_b = OP_W'(sum_y);
      end
      MUL_SXX_SY: begin
        op_a = OP_W'(sum_xx);  op_b = OP_W'(sum_y);
      end
      MUL_SX_SXY: begin
        op_a = OP_W'(sum_x);  op_b = OP_W'(sum_xy);
      end
      default: begin
        op_a = OP_W'(res_val);  op_b = OP_W'(res_val);
      end
    endcase
    a_mag    = op_a[OP_W-1] ? MAG_W'(-op_a) : MAG_W'(op_a);
    b_mag    = op_b[OP_W-1] ? MAG_W'(-op_b) : MAG_W'(op_b);
    prod_s   = mul_neg ? -$signed({1'b0, mul_acc}) : $signed({1'b0, mul_acc});
    prod_n   = $signed(prod_s[NUM_W-1:0]);
    fit_diff = tmp - prod_n;
    term     = (|mul_acc[PROD_W-1:80]) ? '1 : mul_acc[79:16];
    loss_add = {1'b0, loss_sum} + {1'b0, term};

    mag_s = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    mag_i = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    unique case (cmd.div_sel)
      DIV_SLOPE: begin
        dvd_sel = DVD_W'(mag_s) << SLOPE_SH;
        dvs_sel = den[DVS_W-1:0];
        neg_sel = num_s[NUM_W-1];
      end
      DIV_INTC: begin
        dvd_sel = DVD_W'(mag_i) << INTC_SH;
        dvs_sel = den[DVS_W-1:0];
        neg_sel = num_i[NUM_W-1];
      end
      default: begin
        dvd_sel = DVD_W'(loss_sum);
        dvs_sel = DVS_W'(loss_count);
        neg_sel = 1'b0;
      end
    endcase
    trial     = {div_rem, div_dq[DVD_W-1]} - {1'b0, div_dvs};
    coef_res  = coef_sat(div_dq, div_neg);
    mean_over = |div_dq[DVD_W-1:MEAN_W];
    sum_full  = &loss_sum;

    line_hi  = !line_v[LINE_W-1] && (|line_v[LINE_W-2:COEF_W-1]);
    line_lo  = line_v[LINE_W-1] && !(&line_v[LINE_W-2:COEF_W-1]);
    line_sat = line_hi ? COEF_MAX : (line_lo ? COEF_MIN : line_v[COEF_W-1:0]);
  end

  always_comb begin
    stat.mode       = mode_r;
    stat.last       = last_r;
    stat.mul_busy   = mul_busy;
    stat.div_busy   = div_busy;
    stat.den_pos    = !den[NUM_W-1] && (|den);
    stat.loss_full  = (loss_count >= CNT_W'(MAX_SAMPLES));
    stat.loss_empty = (loss_count == '0);
  end

  // Input capture, line evaluation and the fit and loss state.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= mode_in;
      last_r <= last_in;
      x_r    <= x_in;
      y_r    <= y_in;
    end
    if (cmd.line_mul) prod_sx <= slope_reg * x_r;
    if (cmd.line_add) begin
      line_v <= LINE_W'($signed(prod_sx[47:8])) + LINE_W'(intercept_reg);
    end
    if (rst) begin
      fit_count     <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_xy        <= '0;
      slope_reg     <= '0;
      intercept_reg <= '0;
      loss_sum      <= '0;
      loss_count    <= '0;
      err_r         <= 1'b0;
      mean_r        <= '0;
    end else begin
      if (cmd.fit_acc && fit_count < CNT_W'(MAX_SAMPLES)) begin
        fit_count <= fit_count + 1'b1;
        sum_x     <= sum_x + SX_W'(x_r);
        sum_y     <= sum_y + SX_W'(y_r);
        sum_xx    <= sum_xx + SXX_W'(xx);
        sum_xy    <= sum_xy + SXY_W'(xy);
      end
      if (cmd.fit_clr) begin
        fit_count <= '0;
        sum_x     <= '0;
        sum_y     <= '0;
        sum_xx    <= '0;
        sum_xy    <= '0;
      end
      if (cmd.coef_zero) begin
        slope_reg     <= '0;
        intercept_reg <= '0;
        err_r         <= 1'b1;
      end
      if (cmd.mul_store) begin
        unique case (cmd.mul_sel)
          MUL_SX_SX:  den   <= fit_diff;
          MUL_SX_SY:  num_s <= fit_diff;
          MUL_SX_SXY: num_i <= fit_diff;
          MUL_SQUARE: begin
            loss_sum   <= loss_add[LOSS_W] ? '1 : loss_add[LOSS_W-1:0];
            loss_count <= loss_count + 1'b1;
          end
          default:    tmp <= prod_n;
        endcase
      end
      if (cmd.div_store) begin
        unique case (cmd.div_sel)
          DIV_SLOPE: begin
            slope_reg <= $signed(coef_res[COEF_W-1:0]);
            err_r     <= coef_res[COEF_W];
          end
          DIV_INTC: begin
            intercept_reg <= $signed(coef_res[COEF_W-1:0]);
            err_r         <= err_r | coef_res[COEF_W];
          end
          default: begin
            mean_r     <= (mean_over || sum_full) ? '1 : div_dq[MEAN_W-1:0];
            err_r      <= mean_over || sum_full;
            loss_sum   <= '0;
            loss_count <= '0;
          end
        endcase
      end
      if (cmd.mean_empty) begin
        mean_r     <= '0;
        err_r      <= 1'b1;
        loss_sum   <= '0;
        loss_count <= '0;
      end
    end
  end

  // Shift-add multiplier: one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_cnt  <= '0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
      mul_cnt  <= MUL_CNT_W'(MAG_W);
      mul_acc  <= '0;
      mul_mcd  <= PROD_W'(a_mag);
      mul_mlt  <= b_mag;
      mul_neg  <= op_a[OP_W-1] ^ op_b[OP_W-1];
    end else if (mul_busy) begin
      if (mul_mlt[0]) mul_acc <= mul_acc + mul_mcd;
      mul_mcd <= mul_mcd << 1;
      mul_mlt <= mul_mlt >> 1;
      mul_cnt <= mul_cnt - 1'b1;
      if (mul_cnt == MUL_CNT_W'(1)) mul_busy <= 1'b0;
    end
  end

  // Restoring divider: one quotient bit per cycle, dividend shifts out as
  // quotient bits shift in.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_CNT_W'(DVD_W);
      div_rem  <= '0;
      div_dq   <= dvd_sel;
      div_dvs  <= dvs_sel;
      div_neg  <= neg_sel;
    end else if (div_busy) begin
      if (!trial[DVS_W]) begin
        div_rem <= trial[DVS_W-1:0];
      end else begin
        div_rem <= {div_rem[DVS_W-2:0], div_dq[DVD_W-1]};
      end
      div_dq  <= {div_dq[DVD_W-2:0], !trial[DVS_W]};
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == DIV_CNT_W'(1)) div_busy <= 1'b0;
    end
  end

  // Result register; fields outside the result's kind read zero.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_kind <= cmd.out_kind;
      unique case (cmd.out_kind)
        KIND_COEF: begin
          slope_out     <= slope_reg;
          intercept_out <= intercept_reg;
          line_value    <= '0;
          mean_loss     <= '0;
          error_flag    <= err_r;
        end
        KIND_LINE: begin
          slope_out     <= '0;
          intercept_out <= '0;
          line_value    <= $signed(line_sat);
          mean_loss     <= '0;
          error_flag    <= line_hi || line_lo;
        end
        default: begin
          slope_out     <= '0;
          intercept_out <= '0;
          line_value    <= '0;
          mean_loss     <= mean_r;
          error_flag    <= err_r;
        end
      endcase
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the least-squares line fit unit.
// Depends on llsf_pkg and linear_least_squares_fit_unit; stands alone otherwise.
`timescale 1ns / 1ps

module tb import llsf_pkg::*; ;

  // Mode code with no operation; the block must drop such items silently.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int FULL_RUN = 4096;
  localparam logic [63:0] LOSS_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MEAN_LIMIT = (64'd1 << 48) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = MODE_FIT;
  logic signed [15:0] sample_x = '0;
  logic signed [15:0] sample_y = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] result_kind;
  logic signed [31:0] slope_out, intercept_out, line_value;
  logic [47:0] mean_loss;
  logic error_flag;

  linear_least_squares_fit_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .sample_x(sample_x), .sample_y(sample_y), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .slope_out(slope_out), .intercept_out(intercept_out),
    .line_value(line_value), .mean_loss(mean_loss), .error_flag(error_flag)
  );

  typedef struct {
    kind_t              kind;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] line;
    logic [47:0]        mean;
    logic               err;
  } fit_result_t;

  fit_result_t pending_results[$];
  int mismatches = 0;

  // When set, neither side inserts random idle cycles.
  bit calm = 1'b0;
  // Each increment asks the result side for one long hold-off.
  int hold_requests = 0;

  // Shadow copy of the block's state.
  longint fit_n, acc_x, acc_xx, acc_xy, acc_y;
  longint slope_q, intercept_q;
  logic [63:0] loss_acc;
  int loss_n;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Line predictor.
  // ---------------------------------------------------------------------

  // (num << sh) / den truncated toward zero, saturated to 32 signed bits.
  function automatic longint quotient_q16(logic signed [127:0] num, int sh, longint den,
                                          inout bit sat);
    logic [127:0] mag;
    logic [127:0] q;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag << sh;
    q = mag / 128'(den);
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q[63:0]);
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q[63:0]);
  endfunction

  // Slope times x rounded toward minus infinity, plus intercept, unsaturated.
  function automatic longint line_at_x(longint x);
    longint p;
    p = slope_q * x;
    return (p >>> 8) + intercept_q;
  endfunction

  function automatic void clear_fit_sums();
    fit_n = 0; acc_x = 0; acc_xx = 0; acc_xy = 0; acc_y = 0;
  endfunction

  // Update the shadow state with one accepted item and queue its result, if any.
  function automatic void predict_item(logic [1:0] m, longint x, longint y, bit last);
    fit_result_t r;
    longint den, v, res;
    logic signed [127:0] nw, sxw, syw, sxxw, sxyw;
    logic [127:0] mg, sq;
    logic [63:0] term, mean;
    logic [64:0] total;
    bit sat;
    r = '{KIND_COEF, '0, '0, '0, '0, 1'b0};
    sat = 1'b0;
    case (m)
      MODE_FIT: begin
        if (fit_n < FULL_RUN) begin
          fit_n++;
          acc_x += x; acc_y += y; acc_xx += x * x; acc_xy += x * y;
        end
        if (!last) return;
        den = fit_n * acc_xx - acc_x * acc_x;
        if (den <= 0) begin
          slope_q = 0;
          intercept_q = 0;
          r.err = 1'b1;
        end else begin
          nw = fit_n; sxw = acc_x; syw = acc_y; sxxw = acc_xx; sxyw = acc_xy;
          slope_q = quotient_q16(nw * sxyw - sxw * syw, SLOPE_SH, den, sat);
          intercept_q = quotient_q16(sxxw * syw - sxw * sxyw, INTC_SH, den, sat);
          r.slope = slope_q[31:0];
          r.intercept = intercept_q[31:0];
          r.err = sat;
        end
        clear_fit_sums();
        pending_results.push_back(r);
      end
      MODE_EVAL: begin
        v = line_at_x(x);
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647;
          r.err = 1'b1;
        end
        if (v < -64'sd2147483648) begin
          v = -64'sd2147483648;
          r.err = 1'b1;
        end
        r.kind = KIND_LINE;
        r.line = v[31:0];
        pending_results.push_back(r);
      end
      MODE_LOSS: begin
        if (loss_n < FULL_RUN) begin
          res = line_at_x(x) - y * 256;
          mg = (res < 0) ? 128'(-res) : 128'(res);
          sq = mg * mg;
          term = (sq[127:80] != 0) ? LOSS_ALL_ONES : sq[79:16];
          total = {1'b0, loss_acc} + {1'b0, term};
          loss_acc = total[64] ? LOSS_ALL_ONES : total[63:0];
          loss_n++;
        end
        if (!last) return;
        mean = (loss_n != 0) ? loss_acc / 64'(loss_n) : 64'd0;
        if (loss_acc == LOSS_ALL_ONES || loss_n == 0) r.err = 1'b1;
        if (mean > MEAN_LIMIT) begin
          mean = MEAN_LIMIT;
          r.err = 1'b1;
        end
        if (loss_acc == LOSS_ALL_ONES) mean = MEAN_LIMIT;
        r.kind = KIND_LOSS;
        r.mean = mean[47:0];
        loss_acc = '0;
        loss_n = 0;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input side. One call offers one item and returns after its transfer;
  // valid stays high between back-to-back items.
  // ---------------------------------------------------------------------
  task automatic send_item(logic [1:0] m, logic signed [15:0] x, logic signed [15:0] y,
                           bit last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    sample_x <= x;
    sample_y <= y;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    predict_item(m, longint'(x), longint'(y), last);
  endtask

  // Mostly ordinary values, with a share of extremes and small numbers.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      3: return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_run(logic [1:0] m, int len);
    for (int i = 0; i < len; i++)
      send_item(m, pick_value(), pick_value(), i == len - 1);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, long hold-offs on request, and checking.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  int stall_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    fit_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result_kind", 64'(result_kind), 64'd0);
        end else begin
          e = pending_results.pop_front();
          if (result_kind !== e.kind) report_mismatch("result_kind", 64'(result_kind), 64'(e.kind));
          if (slope_out !== e.slope) report_mismatch("slope_out", 64'(slope_out), 64'(e.slope));
          if (intercept_out !== e.intercept)
            report_mismatch("intercept_out", 64'(intercept_out), 64'(e.intercept));
          if (line_value !== e.line) report_mismatch("line_value", 64'(line_value), 64'(e.line));
          if (mean_loss !== e.mean) report_mismatch("mean_loss", 64'(mean_loss), 64'(e.mean));
          if (error_flag !== e.err) report_mismatch("error_flag", 64'(error_flag), 64'(e.err));
        end
      end
      // The hold-off is counted here so that the sender keeps pushing meanwhile.
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        stall_left = 400;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Extreme values in fit, evaluate and loss items.
  task automatic test_extremes();
    send_item(MODE_FIT, 16'sh8000, 16'sh8000, 1'b0);
    send_item(MODE_FIT, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(MODE_FIT, 16'sh0000, 16'sh0000, 1'b1);
    send_item(MODE_EVAL, 16'sh8000, 16'sh0000, 1'b0);
    send_item(MODE_EVAL, 16'sh7FFF, 16'shFFFF, 1'b1);
    send_item(MODE_LOSS, 16'sh8000, 16'sh7FFF, 1'b0);
    send_item(MODE_LOSS, 16'sh7FFF, 16'sh8000, 1'b1);
  endtask

  // Zero denominators: a one-sample run and a run with all x equal.
  task automatic test_degenerate_fits();
    send_item(MODE_FIT, 16'sh0100, 16'sh0200, 1'b1);
    send_item(MODE_FIT, 16'sh0300, 16'sh0100, 1'b0);
    send_item(MODE_FIT, 16'sh0300, 16'sh7000, 1'b1);
    send_item(MODE_EVAL, 16'sh1234, 16'sh0000, 1'b0);
  endtask

  // A steep line saturates the slope; evaluating it then saturates too,
  // and a loss run against it saturates the mean.
  task automatic test_saturation();
    send_item(MODE_FIT, 16'sh0000, 16'sh8000, 1'b0);
    send_item(MODE_FIT, 16'sh0001, 16'sh7FFF, 1'b1);
    send_item(MODE_EVAL, 16'sh7FFF, 16'sh0000, 1'b0);
    send_item(MODE_EVAL, 16'sh8000, 16'sh0000, 1'b0);
    send_item(MODE_LOSS, 16'sh7FFF, 16'sh8000, 1'b0);
    send_item(MODE_LOSS, 16'sh8000, 16'sh7FFF, 1'b1);
    // A steep negative slope.
    send_item(MODE_FIT, 16'sh0000, 16'sh7FFF, 1'b0);
    send_item(MODE_FIT, 16'sh0001, 16'sh8000, 1'b1);
  endtask

  // Items with the unused mode code, including one marked last.
  task automatic test_unused_mode();
    send_item(MODE_NONE, 16'sh7FFF, 16'sh8000, 1'b1);
    send_item(MODE_NONE, 16'sh8000, 16'sh7FFF, 1'b0);
    send_item(MODE_EVAL, 16'sh0080, 16'sh0000, 1'b1);
  endtask

  // The result side holds off for a long stretch while evaluate items keep coming.
  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 30; i++)
      send_item(MODE_EVAL, pick_value(), pick_value(), $urandom_range(0, 1));
  endtask

  // Random mix of well-formed fit and loss runs, evaluations and a little noise.
  task automatic test_random(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
          send_run(MODE_FIT, len);
          sent += len;
        end
        3, 4: begin
          len = $urandom_range(1, 8);
          send_run(MODE_LOSS, len);
          sent += len;
        end
        5: begin
          // Repeated x gives a zero denominator.
          len = $urandom_range(2, 5);
          for (int i = 0; i < len; i++)
            send_item(MODE_FIT, 16'sh0440, pick_value(), i == len - 1);
          sent += len;
        end
        6: begin
          send_item(MODE_NONE, pick_value(), pick_value(), $urandom_range(0, 1));
          sent++;
        end
        default: begin
          send_item(MODE_EVAL, pick_value(), pick_value(), $urandom_range(0, 1));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    int waited;
    fit_n = 0; acc_x = 0; acc_xx = 0; acc_xy = 0; acc_y = 0;
    slope_q = 0; intercept_q = 0; loss_acc = '0; loss_n = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_degenerate_fits();
    test_saturation();
    test_unused_mode();
    test_backpressure();
    test_random(1750);
    calm = 1'b1;
    test_random(200);
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then a closing margin.
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/llsf_pkg.sv
hw/rtl/llsf_ctrl.sv
hw/rtl/llsf_dp.sv
hw/rtl/linear_least_squares_fit_unit.sv
verif/tb.sv
